### src/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

	// decoder modes
	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_TEXT     = 3'd1;
	localparam logic [2:0] MODE_ESC      = 3'd2;
	localparam logic [2:0] MODE_HEX      = 3'd3;
	localparam logic [2:0] MODE_HIGH     = 3'd4;
	localparam logic [2:0] MODE_HIGH_ESC = 3'd5;
	localparam logic [2:0] MODE_LOW_HEX  = 3'd6;

	// end_cause codes
	localparam logic [1:0] CAUSE_NONE   = 2'd0;
	localparam logic [1:0] CAUSE_QUOTE  = 2'd1;
	localparam logic [1:0] CAUSE_BADHEX = 2'd2;
	localparam logic [1:0] CAUSE_END    = 2'd3;

	// kind of the middle segment of an item's results
	localparam logic [1:0] SEG_NONE = 2'd0;
	localparam logic [1:0] SEG_LIT  = 2'd1;
	localparam logic [1:0] SEG_CP   = 2'd2;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	localparam int MaxRes = 7;

	typedef logic [2:0] rcnt_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic [1:0] cause;
	} res_t;

	typedef res_t [MaxRes-1:0] res_vec_t;

	typedef struct packed {
		res_vec_t res;
		rcnt_t    count;
	} dec_res_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] acc;
		logic [1:0]  cnt;
		logic [15:0] ph;
	} dec_state_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} utf8_t;

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t u;
		u = '0;
		if (cp <= 21'h7f) begin
			u.bytes[0] = cp[7:0];
			u.len      = 3'd1;
		end else if (cp <= 21'h7ff) begin
			u.bytes[0] = {3'b110, cp[10:6]};
			u.bytes[1] = {2'b10, cp[5:0]};
			u.len      = 3'd2;
		end else if (cp <= 21'hffff) begin
			u.bytes[0] = {4'b1110, cp[15:12]};
			u.bytes[1] = {2'b10, cp[11:6]};
			u.bytes[2] = {2'b10, cp[5:0]};
			u.len      = 3'd3;
		end else begin
			u.bytes[0] = {5'b11110, cp[20:18]};
			u.bytes[1] = {2'b10, cp[17:12]};
			u.bytes[2] = {2'b10, cp[11:6]};
			u.bytes[3] = {2'b10, cp[5:0]};
			u.len      = 3'd4;
		end
		return u;
	endfunction

	// {ok, digit}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, b[3:0]};
		else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		return r;
	endfunction

	function automatic logic [7:0] esc_map(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			CH_B:    r = 8'h08;
			CH_F:    r = 8'h0c;
			CH_N:    r = 8'h0a;
			CH_R:    r = 8'h0d;
			CH_T:    r = 8'h09;
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic is_high_sur(input logic [15:0] v);
		return v[15:10] == 6'b110110;
	endfunction

	function automatic logic is_low_sur(input logic [15:0] v);
		return v[15:10] == 6'b110111;
	endfunction

endpackage

`default_nettype wire

### src/json_string_unescape_utf8.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------------------------------------------------
// in      | in_valid  | in_stall  | in_byte, byte_present, start_value, text_end
// out     | out_valid | out_stall | out_byte, byte_valid, run_last, value_done, end_cause
//
// An item is registered at acceptance and decoded from that register; its results (0 to 7)
// load into a result buffer once it is free. The buffer delivers one result per cycle while
// out_stall is low; the next item waits in the input stage until the last result is taken;
// items with at most one result flow one per cycle while out_stall is low.
// Reset clears the decoder state to idle and empties both stages; no clearing pass.
// out_stall freezes the buffer; in_stall rises while the input stage waits on it.
`default_nettype none

module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       byte_present,
	input  logic       start_value,
	input  logic       text_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       value_done,
	output logic [1:0] end_cause
);
	import jsu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       start_s1;
	logic       end_s1;

	dec_state_t state_q;
	dec_state_t state_next;
	dec_res_t   dres;
	logic       free;
	logic       load;

	assign load     = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1    <= in_byte;
			present_s1 <= byte_present;
			start_s1   <= start_value;
			end_s1     <= text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_IDLE, acc: '0, cnt: '0, ph: '0};
		end else if (load) begin
			state_q <= state_next;
		end
	end

	jsu_decode u_decode (
		.st_q         (state_q),
		.in_byte      (byte_s1),
		.byte_present (present_s1),
		.start_value  (start_s1),
		.text_end     (end_s1),
		.st_next      (state_next),
		.dres         (dres)
	);

	jsu_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.dres       (dres),
		.free       (free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.value_done (value_done),
		.end_cause  (end_cause)
	);

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_done |-> run_last && !byte_valid && end_cause != CAUSE_NONE)
		else $error("closing result not last of its item");

	a_pending_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.ph != '0 |-> state_q.mode == MODE_HIGH || state_q.mode == MODE_HIGH_ESC
			|| state_q.mode == MODE_LOW_HEX)
		else $error("pending high surrogate outside surrogate modes");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_IDLE |-> state_q.acc == '0 && state_q.cnt == '0)
		else $error("idle decoder holds hex digits");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while result buffer empty");

endmodule

`default_nettype wire

### src/jsu_decode.sv
`default_nettype none

module jsu_decode (
	input  jsu_pkg::dec_state_t st_q,
	input  logic [7:0]          in_byte,
	input  logic                byte_present,
	input  logic                start_value,
	input  logic                text_end,
	output jsu_pkg::dec_state_t st_next,
	output jsu_pkg::dec_res_t   dres
);
	import jsu_pkg::*;

	always_comb begin
		dec_state_t  st;
		logic        emit_a;
		logic [1:0]  seg;
		logic [7:0]  lit;
		logic [20:0] cp;
		logic        close;
		logic [1:0]  cause;
		logic [4:0]  hx;
		logic [15:0] nacc;
		logic [15:0] pa;
		utf8_t       ua;
		utf8_t       ub;
		rcnt_t       n;
		res_vec_t    r;

		st = st_q;
		if (start_value) begin
			st.mode = MODE_TEXT;
			st.acc  = '0;
			st.cnt  = '0;
			st.ph   = '0;
		end
		emit_a = 1'b0;
		seg    = SEG_NONE;
		lit    = '0;
		cp     = '0;
		close  = 1'b0;
		cause  = CAUSE_NONE;
		hx     = hex_digit(in_byte);
		nacc   = {st.acc[11:0], hx[3:0]};
		pa     = st.ph;

		if (byte_present) begin
			unique case (st.mode)
				MODE_TEXT: begin
					if (in_byte == CH_QUOTE) begin
						close = 1'b1;
						cause = CAUSE_QUOTE;
					end else if (in_byte == CH_BSLASH) begin
						st.mode = MODE_ESC;
					end else begin
						seg = SEG_LIT;
						lit = in_byte;
					end
				end
				MODE_ESC: begin
					if (in_byte == CH_U) begin
						st.mode = MODE_HEX;
						st.acc  = '0;
						st.cnt  = '0;
					end else begin
						st.mode = MODE_TEXT;
						seg     = SEG_LIT;
						lit     = esc_map(in_byte);
					end
				end
				MODE_HEX: begin
					if (!hx[4]) begin
						close = 1'b1;
						cause = CAUSE_BADHEX;
					end else if (st.cnt == 2'd3) begin
						st.acc = '0;
						st.cnt = '0;
						if (is_high_sur(nacc)) begin
							st.ph   = nacc;
							st.mode = MODE_HIGH;
						end else begin
							seg     = SEG_CP;
							cp      = {5'b0, nacc};
							st.mode = MODE_TEXT;
						end
					end else begin
						st.acc = nacc;
						st.cnt = st.cnt + 2'd1;
					end
				end
				MODE_HIGH: begin
					if (in_byte == CH_BSLASH) begin
						st.mode = MODE_HIGH_ESC;
					end else begin
						emit_a  = 1'b1;
						st.ph   = '0;
						st.mode = MODE_TEXT;
						if (in_byte == CH_QUOTE) begin
							close = 1'b1;
							cause = CAUSE_QUOTE;
						end else begin
							seg = SEG_LIT;
							lit = in_byte;
						end
					end
				end
				MODE_HIGH_ESC: begin
					if (in_byte == CH_U) begin
						st.mode = MODE_LOW_HEX;
						st.acc  = '0;
						st.cnt  = '0;
					end else begin
						emit_a  = 1'b1;
						st.ph   = '0;
						st.mode = MODE_TEXT;
						seg     = SEG_LIT;
						lit     = esc_map(in_byte);
					end
				end
				MODE_LOW_HEX: begin
					if (!hx[4]) begin
						emit_a = 1'b1;
						close  = 1'b1;
						cause  = CAUSE_BADHEX;
					end else if (st.cnt != 2'd3) begin
						st.acc = nacc;
						st.cnt = st.cnt + 2'd1;
					end else begin
						st.acc = '0;
						st.cnt = '0;
						if (is_low_sur(nacc)) begin
							// pair: 0x10000 + (high - 0xd800) * 1024 + (low - 0xdc00)
							seg     = SEG_CP;
							cp      = {1'b0, st.ph[9:0], nacc[9:0]} + 21'h10000;
							st.ph   = '0;
							st.mode = MODE_TEXT;
						end else begin
							emit_a = 1'b1;
							st.ph  = '0;
							if (is_high_sur(nacc)) begin
								st.ph   = nacc;
								st.mode = MODE_HIGH;
							end else begin
								seg     = SEG_CP;
								cp      = {5'b0, nacc};
								st.mode = MODE_TEXT;
							end
						end
					end
				end
				default: ;
			endcase
		end

		if (close) begin
			st.mode = MODE_IDLE;
			st.acc  = '0;
			st.cnt  = '0;
			st.ph   = '0;
		end

		// end of text; a pending high half only survives a byte that gave no middle segment
		if (text_end && st.mode != MODE_IDLE) begin
			if (st.mode == MODE_HIGH || st.mode == MODE_HIGH_ESC || st.mode == MODE_LOW_HEX) begin
				seg = SEG_CP;
				cp  = {5'b0, st.ph};
			end
			close   = 1'b1;
			cause   = CAUSE_END;
			st.mode = MODE_IDLE;
			st.acc  = '0;
			st.cnt  = '0;
			st.ph   = '0;
		end

		ua = utf8_encode({5'b0, pa});
		ub = utf8_encode(cp);
		r  = '0;
		n  = '0;
		if (emit_a) begin
			for (int k = 0; k < 3; k++) begin
				r[n] = '{data: ua.bytes[k], valid: 1'b1, done: 1'b0, cause: CAUSE_NONE};
				n    = n + rcnt_t'(1);
			end
		end
		if (seg == SEG_LIT) begin
			r[n] = '{data: lit, valid: 1'b1, done: 1'b0, cause: CAUSE_NONE};
			n    = n + rcnt_t'(1);
		end else if (seg == SEG_CP) begin
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < ub.len) begin
					r[n] = '{data: ub.bytes[k], valid: 1'b1, done: 1'b0, cause: CAUSE_NONE};
					n    = n + rcnt_t'(1);
				end
			end
		end
		if (close) begin
			r[n] = '{data: 8'h00, valid: 1'b0, done: 1'b1, cause: cause};
			n    = n + rcnt_t'(1);
		end

		st_next    = st;
		dres.res   = r;
		dres.count = n;
	end

endmodule

`default_nettype wire

### src/jsu_outbuf.sv
`default_nettype none

module jsu_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jsu_pkg::dec_res_t dres,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              run_last,
	output logic              value_done,
	output logic [1:0]        end_cause
);
	import jsu_pkg::*;

	res_vec_t res_q;
	rcnt_t    cnt_q;
	rcnt_t    idx_q;
	res_t     head;

	// cnt_q counts results still to deliver for the buffered item
	assign out_valid = cnt_q != '0;
	assign free      = (cnt_q == '0) || (cnt_q == rcnt_t'(1) && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= dres.count;
			idx_q <= '0;
		end else if (out_valid && !out_stall) begin
			cnt_q <= cnt_q - rcnt_t'(1);
			idx_q <= idx_q + rcnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= dres.res;
	end

	assign head       = res_q[idx_q];
	assign out_byte   = head.data;
	assign byte_valid = head.valid;
	assign value_done = head.done;
	assign end_cause  = head.cause;
	assign run_last   = cnt_q == rcnt_t'(1);

endmodule

`default_nettype wire
